@@ design/lss_pkg.sv @@
package lss_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int COUNT_BITS = 32;
  localparam int WINDOW_BYTES = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int WINDOW_BITS = WINDOW_BYTES * 8;
  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_INVERT       = 3'd3,
    REG_LIMIT_EN     = 3'd4,
    REG_LINE_LIMIT   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [127:0]          pattern;
    logic [LEN_BITS-1:0]   length;
    logic                  invert;
    logic                  limit_en;
    logic [31:0]           limit;
  } lss_cfg_t;

endpackage

@@ design/lss_cfg.sv @@
module lss_cfg import lss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output lss_cfg_t             cfg
);

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic        invert_select;
  logic        limit_enable;
  logic [31:0] line_limit;
  reg_index_t  index;
  logic        wr;

  assign pready = 1'b1;
  assign index = reg_index_t'(paddr[5:3]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low <= '0;
      pattern_high <= '0;
      pattern_length <= '0;
      invert_select <= 1'b0;
      limit_enable <= 1'b0;
      line_limit <= '0;
    end else if (wr) begin
      unique case (index)
        REG_PATTERN_LOW:  pattern_low <= pwdata;
        REG_PATTERN_HIGH: pattern_high <= pwdata;
        REG_PATTERN_LEN:  pattern_length <= pwdata[4:0];
        REG_INVERT:       invert_select <= pwdata[0];
        REG_LIMIT_EN:     limit_enable <= pwdata[0];
        REG_LINE_LIMIT:   line_limit <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_PATTERN_LEN:  prdata = DATA_BITS'(pattern_length);
      REG_INVERT:       prdata = DATA_BITS'(invert_select);
      REG_LIMIT_EN:     prdata = DATA_BITS'(limit_enable);
      REG_LINE_LIMIT:   prdata = DATA_BITS'(line_limit);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    if (pattern_length > 5'(PATTERN_MAX)) begin
      cfg.length = LEN_BITS'(PATTERN_MAX);
    end else begin
      cfg.length = LEN_BITS'(pattern_length);
    end
    cfg.invert = invert_select;
    cfg.limit_en = limit_enable;
    cfg.limit = line_limit;
  end

endmodule

@@ design/lss_match.sv @@
module lss_match import lss_pkg::*; (
  input  logic [7:0]             cur,
  input  logic [WINDOW_BITS-1:0] recent,
  input  logic [LEN_BITS-1:0]    bytes_in_line,
  input  lss_cfg_t               cfg,
  output logic                   hit
);

  logic [7:0] win [PATTERN_MAX];
  logic       eq [PATTERN_MAX][PATTERN_MAX];
  logic       len_match [PATTERN_MAX+1];

  always_comb begin
    win[0] = cur;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win[j] = recent[(j-1)*8 +: 8];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        eq[j][i] = (win[j] == cfg.pattern[i*8 +: 8]);
      end
    end
    len_match[0] = 1'b1;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      len_match[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        len_match[l] = len_match[l] && eq[j][l-1-j];
      end
    end
  end

  always_comb begin
    if (cfg.length == '0) begin
      hit = 1'b1;
    end else begin
      hit = len_match[cfg.length] && (bytes_in_line >= LEN_BITS'(cfg.length - 1'b1));
    end
  end

endmodule

@@ design/line_substring_selector_core.sv @@
// A byte passes the s1 byte register and then the result register before it leaves.
// One byte per cycle unless result_stall holds; the window is compared in parallel.
// Only a newline byte or an end-of-stream byte yields a result transaction.
// Reset clears the configuration registers, the line window and the internal count.
// End of stream clears the count and the window after its result is formed.
module line_substring_selector_core import lss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 line_selected,
  output logic [31:0]          selected_count,
  output logic                 stream_done
);

  lss_cfg_t cfg;

  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_eos;
  logic [WINDOW_BITS-1:0] recent;
  logic [LEN_BITS-1:0]    bytes_in_line;
  logic                   pattern_seen;
  logic [COUNT_BITS-1:0]  line_count;

  logic                   advance;
  logic                   work;
  logic                   hit;
  logic                   is_newline;
  logic                   line_end;
  logic                   seen_next;
  logic                   contains;
  logic                   sel;
  logic [COUNT_BITS-1:0]  line_count_next;

  lss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lss_match u_match (
    .cur           (s1_byte),
    .recent        (recent),
    .bytes_in_line (bytes_in_line),
    .cfg           (cfg),
    .hit           (hit)
  );

  assign advance = !result_valid || !result_stall;
  assign byte_stall = s1_valid && !advance;
  assign work = s1_valid && advance;

  always_comb begin
    is_newline = (s1_byte == NEWLINE_BYTE);
    line_end = is_newline || s1_eos;
    seen_next = pattern_seen || (!is_newline && hit);
    contains = seen_next || (cfg.length == '0);
    sel = contains ^ cfg.invert;
    if (cfg.limit_en && (32'(line_count) >= cfg.limit)) begin
      sel = 1'b0;
    end
    line_count_next = line_count;
    if (sel && (line_count != '1)) begin
      line_count_next = line_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      s1_byte <= data_byte;
      s1_eos <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
      bytes_in_line <= '0;
      pattern_seen <= 1'b0;
      line_count <= '0;
    end else if (work) begin
      if (line_end) begin
        recent <= '0;
        bytes_in_line <= '0;
        pattern_seen <= 1'b0;
        line_count <= s1_eos ? '0 : line_count_next;
      end else begin
        recent <= WINDOW_BITS'({recent, s1_byte});
        if (bytes_in_line < LEN_BITS'(WINDOW_BYTES)) begin
          bytes_in_line <= bytes_in_line + 1'b1;
        end
        pattern_seen <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= work && line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (work && line_end) begin
      line_selected <= sel;
      selected_count <= 32'(line_count_next);
      stream_done <= s1_eos;
    end
  end

endmodule
